FILE: design/pip_pkg.sv
// Package for the point-in-polygon test block: sizes, stream packing and the
// structs that pass between the vertex cells, the edge unit and the top level.
// No dependencies.
`timescale 1ns / 1ps

package pip_pkg;

    // Table size and coordinate width.
    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;

    // Derived widths.
    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W + 1;

    // Stream packing.
    localparam int VTOTAL_W     = 7;
    localparam int IN_DATA_W    = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int IN_USER_W    = 2;
    localparam int OUT_FIELDS_W = 2 + VTOTAL_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Request kinds carried in the low tuser bit.
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Control for one vertex cell: shift is common to all cells, write is per cell.
    typedef struct packed {
        logic shift;    // take the neighbor's vertex
        logic write;    // take the appended vertex
    } cell_ctrl_t;

    // One edge to test against the query point: cx,cy is vertex i, jx,jy is vertex i-1.
    typedef struct packed {
        logic                  valid;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] jx;
        logic [COORD_BITS-1:0] jy;
    } edge_req_t;

endpackage

FILE: design/pip_cell.sv
// One vertex cell of the circular vertex chain.
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_cell
(
    input  logic                           clk,
    input  pip_pkg::cell_ctrl_t            ctrl,
    input  logic [pip_pkg::COORD_BITS-1:0] wr_x,
    input  logic [pip_pkg::COORD_BITS-1:0] wr_y,
    input  logic [pip_pkg::COORD_BITS-1:0] nb_x,
    input  logic [pip_pkg::COORD_BITS-1:0] nb_y,
    output logic [pip_pkg::COORD_BITS-1:0] vx,
    output logic [pip_pkg::COORD_BITS-1:0] vy
);

    logic [pip_pkg::COORD_BITS-1:0] x_reg;
    logic [pip_pkg::COORD_BITS-1:0] y_reg;
    logic [pip_pkg::COORD_BITS-1:0] x_next;
    logic [pip_pkg::COORD_BITS-1:0] y_next;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        priority if (ctrl.write)
        begin
            x_next = wr_x;
            y_next = wr_y;
        end
        else if (ctrl.shift)
        begin
            x_next = nb_x;
            y_next = nb_y;
        end
        else
        begin
            x_next = x_reg;
            y_next = y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign vx = x_reg;
    assign vy = y_reg;

endmodule

FILE: design/pip_edge.sv
// Pipelined crossing test of one polygon edge against the query point.
// Stage one forms the differences, stage two the two cross products; the
// compare after stage two drives the parity toggle. Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_edge
(
    input  logic                clk,
    input  logic                rst_n,
    input  pip_pkg::edge_req_t  req,
    output logic                toggle
);

    logic                               s1_valid_reg;
    logic                               s1_valid_next;
    logic signed [pip_pkg::DIFF_W-1:0]  dx_reg;
    logic signed [pip_pkg::DIFF_W-1:0]  dy_reg;
    logic signed [pip_pkg::DIFF_W-1:0]  a_reg;
    logic signed [pip_pkg::DIFF_W-1:0]  b_reg;
    logic signed [pip_pkg::DIFF_W-1:0]  dx_next;
    logic signed [pip_pkg::DIFF_W-1:0]  dy_next;
    logic signed [pip_pkg::DIFF_W-1:0]  a_next;
    logic signed [pip_pkg::DIFF_W-1:0]  b_next;

    logic                               s2_valid_reg;
    logic                               dy_pos_reg;
    logic signed [pip_pkg::PROD_W-1:0]  p1_reg;
    logic signed [pip_pkg::PROD_W-1:0]  p2_reg;
    logic signed [pip_pkg::PROD_W-1:0]  p1_next;
    logic signed [pip_pkg::PROD_W-1:0]  p2_next;
    logic                               dy_pos_next;

    logic signed [pip_pkg::DIFF_W-1:0]  px_s;
    logic signed [pip_pkg::DIFF_W-1:0]  py_s;
    logic signed [pip_pkg::DIFF_W-1:0]  cx_s;
    logic signed [pip_pkg::DIFF_W-1:0]  cy_s;
    logic signed [pip_pkg::DIFF_W-1:0]  jx_s;
    logic signed [pip_pkg::DIFF_W-1:0]  jy_s;

    always_comb
    begin
        px_s = pip_pkg::DIFF_W'($signed(req.px));
        py_s = pip_pkg::DIFF_W'($signed(req.py));
        cx_s = pip_pkg::DIFF_W'($signed(req.cx));
        cy_s = pip_pkg::DIFF_W'($signed(req.cy));
        jx_s = pip_pkg::DIFF_W'($signed(req.jx));
        jy_s = pip_pkg::DIFF_W'($signed(req.jy));
        // Only edges that straddle the query y can produce a crossing.
        s1_valid_next = req.valid && ((cy_s > py_s) != (jy_s > py_s));
        dx_next = jx_s - cx_s;
        dy_next = jy_s - cy_s;
        a_next  = px_s - cx_s;
        b_next  = py_s - cy_s;
    end

    always_comb
    begin
        p1_next     = pip_pkg::PROD_W'(a_reg) * pip_pkg::PROD_W'(dy_reg);
        p2_next     = pip_pkg::PROD_W'(dx_reg) * pip_pkg::PROD_W'(b_reg);
        dy_pos_next = (dy_reg > 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        dy_pos_reg <= dy_pos_next;
    end

    // The point is left of the crossing when (px-cx) < dx*(py-cy)/dy; multiplying
    // through by dy flips the compare when dy is negative.
    assign toggle = s2_valid_reg && (dy_pos_reg ? (p1_reg < p2_reg) : (p2_reg < p1_reg));

endmodule

FILE: design/point_in_polygon_test.sv
// Top level of the point-in-polygon test: controller, circular chain of vertex
// cells, edge unit and output register. Depends on pip_pkg, pip_cell, pip_edge.
//
//  Channel | Direction | Handshake        | Contents
//  s       | in        | s_tvalid/tready  | tuser: kind, restart; tdata: coord_x, coord_y
//  m       | out       | m_tvalid/tready  | tdata: inside_res, truncated, vertex_total
//
// During a query the vertex ring rotates once past the edge unit at one edge per
// cycle, then the closing edge is issued and the two-stage edge pipeline drains.
// Reset clears the vertex count, the truncated flag and all control; the vertex
// cells are not cleared. A result waiting on m holds only the next query's
// finish; appends keep flowing meanwhile.
`timescale 1ns / 1ps

module point_in_polygon_test
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pip_pkg::IN_DATA_W-1:0]   s_tdata,   // coord_x, coord_y
    input  logic [pip_pkg::IN_USER_W-1:0]   s_tuser,   // kind, restart
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pip_pkg::OUT_DATA_W-1:0]  m_tdata    // inside_res, truncated, vertex_total
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROT   = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int CW = pip_pkg::COORD_BITS;
    localparam logic [pip_pkg::IDX_W-1:0] LAST_STEP = pip_pkg::IDX_W'(pip_pkg::MAX_VERTICES - 1);
    localparam logic [pip_pkg::CNT_W-1:0] FULL_CNT  = pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES);

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [pip_pkg::CNT_W-1:0]        count_reg;
    logic [pip_pkg::CNT_W-1:0]        count_next;
    logic                             dropped_reg;
    logic                             dropped_next;
    logic [pip_pkg::CNT_W-1:0]        n_reg;
    logic [pip_pkg::CNT_W-1:0]        n_next;
    logic [pip_pkg::IDX_W-1:0]        step_reg;
    logic [pip_pkg::IDX_W-1:0]        step_next;
    logic                             drain_reg;
    logic                             drain_next;
    logic                             parity_reg;
    logic                             parity_next;
    logic [CW-1:0]                    px_reg;
    logic [CW-1:0]                    py_reg;
    logic [CW-1:0]                    prev_x_reg;
    logic [CW-1:0]                    prev_y_reg;
    logic [CW-1:0]                    first_x_reg;
    logic [CW-1:0]                    first_y_reg;
    logic [CW-1:0]                    px_next;
    logic [CW-1:0]                    py_next;
    logic [CW-1:0]                    prev_x_next;
    logic [CW-1:0]                    prev_y_next;
    logic [CW-1:0]                    first_x_next;
    logic [CW-1:0]                    first_y_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [pip_pkg::OUT_DATA_W-1:0]   out_data_reg;
    logic [pip_pkg::OUT_DATA_W-1:0]   out_data_next;

    logic                             s_accept;
    logic                             in_kind;
    logic                             in_restart;
    logic [CW-1:0]                    in_x;
    logic [CW-1:0]                    in_y;
    logic                             wr_ok;
    logic [pip_pkg::IDX_W-1:0]        wr_idx;
    logic                             do_write;
    logic                             do_shift;
    logic                             step_in_poly;
    logic                             toggle;
    pip_pkg::edge_req_t               req;

    logic [CW-1:0] ring_x [pip_pkg::MAX_VERTICES];
    logic [CW-1:0] ring_y [pip_pkg::MAX_VERTICES];

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign in_kind    = s_tuser[0];
    assign in_restart = s_tuser[1];
    assign in_x       = s_tdata[CW-1:0];
    assign in_y       = s_tdata[2*CW-1:CW];

    // A restart always lands in cell zero; otherwise the vertex goes after the last one, unless the table is full.
    assign wr_ok    = in_restart || (count_reg < FULL_CNT);
    assign wr_idx   = in_restart ? '0 : count_reg[pip_pkg::IDX_W-1:0];
    assign do_write = s_accept && (in_kind == pip_pkg::KIND_APPEND) && wr_ok;
    assign do_shift = (state_reg == ST_ROT);

    genvar k;
    generate
        for (k = 0; k < pip_pkg::MAX_VERTICES; k++)
        begin : g_cell
            pip_pkg::cell_ctrl_t cctrl;
            assign cctrl.shift = do_shift;
            assign cctrl.write = do_write && (wr_idx == pip_pkg::IDX_W'(k));
            pip_cell u_cell
            (
                .clk  (clk),
                .ctrl (cctrl),
                .wr_x (in_x),
                .wr_y (in_y),
                .nb_x (ring_x[(k + 1) % pip_pkg::MAX_VERTICES]),
                .nb_y (ring_y[(k + 1) % pip_pkg::MAX_VERTICES]),
                .vx   (ring_x[k]),
                .vy   (ring_y[k])
            );
        end
    endgenerate

    // Cell zero holds vertex step during rotation.
    assign step_in_poly = ({1'b0, step_reg} < n_reg);

    always_comb
    begin
        req.valid = 1'b0;
        req.px    = px_reg;
        req.py    = py_reg;
        req.cx    = ring_x[0];
        req.cy    = ring_y[0];
        req.jx    = prev_x_reg;
        req.jy    = prev_y_reg;
        unique case (state_reg)
            ST_ROT:
            begin
                req.valid = step_in_poly && (step_reg != '0);
            end
            ST_CLOSE:
            begin
                req.valid = (n_reg != '0);
                req.cx    = first_x_reg;
                req.cy    = first_y_reg;
            end
            default:
            begin
                req.valid = 1'b0;
            end
        endcase
    end

    pip_edge u_edge
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .toggle (toggle)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        n_next         = n_reg;
        step_next      = step_reg;
        drain_next     = drain_reg;
        parity_next    = parity_reg ^ toggle;
        px_next        = px_reg;
        py_next        = py_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_kind == pip_pkg::KIND_APPEND)
                    begin
                        priority if (in_restart)
                        begin
                            count_next   = pip_pkg::CNT_W'(1);
                            dropped_next = 1'b0;
                        end
                        else if (wr_ok)
                        begin
                            count_next = count_reg + pip_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    else
                    begin
                        px_next     = in_x;
                        py_next     = in_y;
                        n_next      = count_reg;
                        step_next   = '0;
                        parity_next = 1'b0;
                        state_next  = ST_ROT;
                    end
                end
            end
            ST_ROT:
            begin
                if (step_in_poly)
                begin
                    prev_x_next = ring_x[0];
                    prev_y_next = ring_y[0];
                    if (step_reg == '0)
                    begin
                        first_x_next = ring_x[0];
                        first_y_next = ring_y[0];
                    end
                end
                step_next = step_reg + pip_pkg::IDX_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                drain_next = 1'b0;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // Waiting here until drain_reg is set lets the last edge reach the parity register.
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pip_pkg::OUT_DATA_W'({
                        pip_pkg::VTOTAL_W'(n_reg), dropped_reg, parity_reg});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            n_reg         <= '0;
            step_reg      <= '0;
            drain_reg     <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            n_reg         <= n_next;
            step_reg      <= step_next;
            drain_reg     <= drain_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        first_x_reg  <= first_x_next;
        first_y_reg  <= first_y_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for point_in_polygon_test: appends vertices, queries
// points and checks each answer against a crossing-number predictor kept here.
// Depends on pip_pkg and the point_in_polygon_test top level.
`timescale 1ns / 1ps

module tb_top;

    localparam int RUN_LIMIT   = 1000000;
    localparam int ITEMS_PHASE = 256;
    localparam int TAIL_CYCLES = 2 * (pip_pkg::MAX_VERTICES + 5) + 10;

    typedef struct packed {
        logic                         in_poly;
        logic                         trunc;
        logic [pip_pkg::VTOTAL_W-1:0] total;
    } answer_t;

    typedef struct {
        logic    kind;
        logic    restart;
        shortint x;
        shortint y;
        logic    pinned;
        answer_t pinned_ans;
    } row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [pip_pkg::IN_DATA_W-1:0]  s_tdata = '0;     // coord_x, coord_y
    logic [pip_pkg::IN_USER_W-1:0]  s_tuser = '0;     // kind, restart
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pip_pkg::OUT_DATA_W-1:0] m_tdata;          // inside_res, truncated, vertex_total

    // Polygon as the testbench believes the block holds it.
    shortint vtx_x [pip_pkg::MAX_VERTICES];
    shortint vtx_y [pip_pkg::MAX_VERTICES];
    int      vtx_count = 0;
    logic    vtx_dropped = 1'b0;

    answer_t     answers_due [$];
    row_t        plan [$];
    int          mismatches = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          sent_items = 0;
    int unsigned cycles = 0;

    point_in_polygon_test dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic flag_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_row(row_t r);
        plan.insert(plan.size(), r);
    endtask

    // Even-odd crossing count. The division of the classic test is replaced by
    // a cross-multiplied compare whose direction follows the sign of dy.
    function automatic logic point_inside(shortint px, shortint py);
        logic   odd;
        int     j;
        longint dx;
        longint dy;
        longint lhs;
        longint rhs;
        odd = 1'b0;
        j = vtx_count - 1;
        for (int i = 0; i < vtx_count; i++)
        begin
            if ((vtx_y[i] > py) != (vtx_y[j] > py))
            begin
                dx  = longint'(vtx_x[j]) - longint'(vtx_x[i]);
                dy  = longint'(vtx_y[j]) - longint'(vtx_y[i]);
                lhs = (longint'(px) - longint'(vtx_x[i])) * dy;
                rhs = dx * (longint'(py) - longint'(vtx_y[i]));
                if ((dy > 0) ? (lhs < rhs) : (rhs < lhs))
                    odd = ~odd;
            end
            j = i;
        end
        return odd;
    endfunction

    task automatic polygon_accept(logic kind, logic restart, shortint x, shortint y,
                                  logic pinned, answer_t pinned_ans);
        answer_t ans;
        if (kind == pip_pkg::KIND_APPEND)
        begin
            if (restart)
            begin
                vtx_count   = 0;
                vtx_dropped = 1'b0;
            end
            if (vtx_count < pip_pkg::MAX_VERTICES)
            begin
                vtx_x[vtx_count] = x;
                vtx_y[vtx_count] = y;
                vtx_count++;
            end
            else
                vtx_dropped = 1'b1;
        end
        else
        begin
            ans.in_poly = point_inside(x, y);
            ans.trunc   = vtx_dropped;
            ans.total   = pip_pkg::VTOTAL_W'(vtx_count);
            answers_due.insert(answers_due.size(), pinned ? pinned_ans : ans);
        end
    endtask

    task automatic send_request(logic kind, logic restart, shortint x, shortint y,
                                logic pinned, answer_t pinned_ans);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {16'(y), 16'(x)};
        s_tuser  <= {restart, kind};
        do
            @(posedge clk);
        while (!s_tready);
        polygon_accept(kind, restart, x, y, pinned, pinned_ans);
        sent_items++;
    endtask

    task automatic send_plain(logic kind, logic restart, shortint x, shortint y);
        send_request(kind, restart, x, y, 1'b0, '0);
    endtask

    function automatic row_t mk(logic kind, logic restart, int x, int y, logic pinned,
                                logic in_poly, logic trunc, int total);
        row_t r;
        r.kind               = kind;
        r.restart            = restart;
        r.x                  = shortint'(x);
        r.y                  = shortint'(y);
        r.pinned             = pinned;
        r.pinned_ans.in_poly = in_poly;
        r.pinned_ans.trunc   = trunc;
        r.pinned_ans.total   = pip_pkg::VTOTAL_W'(total);
        return r;
    endfunction

    function automatic shortint clip_coord(int v);
        if (v > 32767)
            return shortint'(32767);
        if (v < -32768)
            return shortint'(-32768);
        return shortint'(v);
    endfunction

    // One polygon, sometimes after random requests, then a few queries. Every eighth
    // polygon may overfill the table, exercising the truncated flag and full-table restart.
    task automatic polygon_burst(int burst_no);
        int      n;
        int      nq;
        int      cx;
        int      cy;
        int      r;
        int      idx;
        logic    wide;
        logic    keep;
        shortint qx;
        shortint qy;
        if ($urandom_range(4) == 0)
        begin
            for (int k = 0; k <= $urandom_range(2); k++)
                send_plain(1'($urandom()), 1'($urandom()), shortint'($urandom()),
                           shortint'($urandom()));
        end
        n    = (burst_no % 8 == 3) ? $urandom_range(60, 72) : $urandom_range(1, 12);
        keep = ($urandom_range(5) == 0);
        wide = ($urandom_range(3) == 0);
        cx   = int'($urandom_range(60000)) - 30000;
        cy   = int'($urandom_range(60000)) - 30000;
        r    = ($urandom_range(3) == 0) ? $urandom_range(1, 40000) : $urandom_range(1, 2000);
        for (int k = 0; k < n; k++)
        begin
            if (wide)
                send_plain(pip_pkg::KIND_APPEND, (k == 0) && !keep, shortint'($urandom()),
                           shortint'($urandom()));
            else
                send_plain(pip_pkg::KIND_APPEND, (k == 0) && !keep,
                           clip_coord(cx + int'($urandom_range(2 * r)) - r),
                           clip_coord(cy + int'($urandom_range(2 * r)) - r));
        end
        nq = $urandom_range(1, 6);
        for (int k = 0; k < nq; k++)
        begin
            if (wide)
            begin
                qx = shortint'($urandom());
                qy = shortint'($urandom());
            end
            else
            begin
                qx = clip_coord(cx + int'($urandom_range(2 * r)) - r);
                qy = clip_coord(cy + int'($urandom_range(2 * r)) - r);
            end
            // Land on a vertex coordinate now and then to hit the boundary cases.
            if (vtx_count > 0 && $urandom_range(2) == 0)
            begin
                idx = $urandom_range(vtx_count - 1);
                case ($urandom_range(2))
                    0: qx = vtx_x[idx];
                    1: qy = vtx_y[idx];
                    default:
                    begin
                        qx = vtx_x[idx];
                        qy = vtx_y[idx];
                    end
                endcase
            end
            send_plain(pip_pkg::KIND_QUERY, 1'($urandom()), qx, qy);
        end
    endtask

    // Result checker and receiver backpressure.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answers_due.size() == 0)
                flag_mismatch($sformatf("unexpected result %h", m_tdata));
            else
            begin
                want = answers_due.pop_front();
                if (m_tdata[0] !== want.in_poly)
                    flag_mismatch($sformatf("inside_res %b, want %b", m_tdata[0],
                                            want.in_poly));
                if (m_tdata[1] !== want.trunc)
                    flag_mismatch($sformatf("truncated %b, want %b", m_tdata[1], want.trunc));
                if (m_tdata[2 +: pip_pkg::VTOTAL_W] !== want.total)
                    flag_mismatch($sformatf("vertex_total %0d, want %0d",
                                            m_tdata[2 +: pip_pkg::VTOTAL_W], want.total));
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic drain_answers();
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int burst_no;
        int phase_end;
        burst_no = 0;

        //         kind                  rst  x       y       pin  in  tr  total
        add_row(mk(pip_pkg::KIND_QUERY,  0,   0,      0,      1,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 1,   5,      5,      0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   5,      4,      1,   0,  0,  1));
        add_row(mk(pip_pkg::KIND_APPEND, 1,   -100,   -100,   0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 0,   100,    -100,   0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 0,   100,    100,    0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 0,   -100,   100,    0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   0,      0,      0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  1,   200,    0,      0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   -100,   -100,   0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   0,      -100,   0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 1,   -32768, -32768, 0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 0,   32767,  -32768, 0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 0,   32767,  32767,  0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 0,   -32768, 32767,  0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   0,      0,      0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   -32768, 0,      0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   32767,  -1,     0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   -32768, -32768, 0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 1,   0,      -32768, 0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 0,   32767,  32767,  0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_APPEND, 0,   -32768, 32767,  0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   0,      32767,  0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   -1,     0,      0,   0,  0,  0));
        add_row(mk(pip_pkg::KIND_QUERY,  0,   32767,  -32768, 0,   0,  0,  0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            send_request(plan[k].kind, plan[k].restart, plan[k].x, plan[k].y,
                         plan[k].pinned, plan[k].pinned_ans);

        // Random phases: no idling, idle sender, stalling receiver, then both lightly.
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct  = (phase == 1) ? 88 : (phase == 3) ? 12 : 0;
            stall_pct = (phase == 2) ? 88 : (phase == 3) ? 12 : 0;
            phase_end = sent_items + ITEMS_PHASE;
            while (sent_items < phase_end)
            begin
                polygon_burst(burst_no);
                burst_no++;
            end
            // Hold the sender until every outstanding answer has come back.
            s_tvalid <= 1'b0;
            @(posedge clk);
            drain_answers();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: point_in_polygon_test.f
design/pip_pkg.sv
design/pip_cell.sv
design/pip_edge.sv
design/point_in_polygon_test.sv
verif/tb_top.sv
